@@ hw/rtl/pvm_pkg.sv @@
package pvm_pkg;

    // Channel count and field widths
    localparam int CHANNELS  = 2;
    localparam int CH_W      = 1;
    localparam int US_W      = 14;
    localparam int SUM_W     = US_W + 1;
    localparam int FREQ_W    = 22;
    localparam int VOLT_W    = 18;
    localparam int OFS_W     = 16;
    localparam int SCALE_W   = 24;
    localparam int RETRY_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Reciprocal divider: 256e6 as a 28 bit numerator, one quotient bit per step
    localparam int DIV_BITS = 28;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_BITS-1:0] FREQ_NUM = 28'd256000000;

    // Sums up to this value give a quotient above the field maximum
    localparam logic [SUM_W-1:0] SAT_SUM = 15'd61;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 22'd4194303;
    localparam logic [VOLT_W-1:0] VOLT_MAX = 18'd262143;
    localparam logic [FREQ_W-1:0] F_LOW    = 22'd25600;
    localparam logic [FREQ_W-1:0] F_HIGH   = 22'd2048000;

    // Product of difference (23 bit) and scale (24 bit)
    localparam int DIFF_W = FREQ_W + 2;
    localparam int PROD_W = (DIFF_W - 1) + SCALE_W;

    // Register reset values
    localparam logic [OFS_W-1:0]   TS_OFFSET_RST   = 16'hFC47;  // -953
    localparam logic [SCALE_W-1:0] TS_SCALE_RST    = 24'd1503790;
    localparam logic [OFS_W-1:0]   ACCU_OFFSET_RST = 16'd36;
    localparam logic [SCALE_W-1:0] ACCU_SCALE_RST  = 24'd1476258;
    localparam logic [VOLT_W-1:0]  MIN_VOLT_RST    = 18'd1280;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TS_OFFSET   = 3'd0,
        CFG_TS_SCALE    = 3'd1,
        CFG_ACCU_OFFSET = 3'd2,
        CFG_ACCU_SCALE  = 3'd3,
        CFG_MIN_VOLT    = 3'd4,
        CFG_RETRY_LIMIT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [OFS_W-1:0]   ts_offset;
        logic [SCALE_W-1:0] ts_scale;
        logic [OFS_W-1:0]   accu_offset;
        logic [SCALE_W-1:0] accu_scale;
        logic [VOLT_W-1:0]  min_voltage;
        logic [RETRY_W-1:0] retry_limit;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic check;
        logic mul;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ch_ok;
        logic div_last;
        logic retry;
        logic out_full;
    } t_dp_sts;

    typedef struct packed {
        logic [CH_W-1:0]    result_channel;
        logic [VOLT_W-1:0]  voltage_q8;
        logic [FREQ_W-1:0]  frequency_q8;
        logic               in_bounds;
        logic [RETRY_W-1:0] retries_used;
    } t_result;

endpackage

@@ hw/rtl/pvm_in_if.sv @@
interface pvm_in_if
    import pvm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [US_W-1:0]   high_us;
    logic [US_W-1:0]   low_us;

    modport source (output valid, output channel, output high_us, output low_us,
                    input ready);
    modport sink   (input valid, input channel, input high_us, input low_us,
                    output ready);
endinterface

@@ hw/rtl/pvm_out_if.sv @@
interface pvm_out_if
    import pvm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    result_channel;
    logic [VOLT_W-1:0]  voltage_q8;
    logic [FREQ_W-1:0]  frequency_q8;
    logic               in_bounds;
    logic [RETRY_W-1:0] retries_used;

    modport source (output valid, output result_channel, output voltage_q8,
                    output frequency_q8, output in_bounds, output retries_used,
                    input ready);
    modport sink   (input valid, input result_channel, input voltage_q8,
                    input frequency_q8, input in_bounds, input retries_used,
                    output ready);
endinterface

@@ hw/rtl/pulse_period_to_voltage_meter_unit.sv @@
// Pulse-period voltage meter for two voltage-to-frequency converters.
// Input channel i_in: one transaction carries a channel number and the
// measured high and low widths in microseconds. Output channel o_out: one
// transaction carries the channel, voltage (Q.8 V), frequency (Q.8 Hz),
// the in-window flag and the number of retries that preceded it.
// Both channels use valid/ready; a transaction moves when both are high.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx.
// Timing: an accepted item passes through the bit-serial reciprocal
// divider, the window and retry check, the calibration multiplier and the
// output register load, and the block accepts no new item until it has
// returned to idle. An item whose frequency is out of window and still has
// retries left returns the block to idle after the check, with no output.
// A finished result sits in the output register; if the receiver stalls,
// the next item is still accepted and processed and waits for the register.
// Reset (synchronous, active low) clears the retry counters, drops the
// output valid and restores the calibration registers to their defaults.
module pulse_period_to_voltage_meter_unit
    import pvm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pvm_in_if.sink                i_in,
    pvm_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ts_offset   <= TS_OFFSET_RST;
            r_cfg.ts_scale    <= TS_SCALE_RST;
            r_cfg.accu_offset <= ACCU_OFFSET_RST;
            r_cfg.accu_scale  <= ACCU_SCALE_RST;
            r_cfg.min_voltage <= MIN_VOLT_RST;
            r_cfg.retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TS_OFFSET:   r_cfg.ts_offset   <= i_cfg_wdata[OFS_W-1:0];
                CFG_TS_SCALE:    r_cfg.ts_scale    <= i_cfg_wdata[SCALE_W-1:0];
                CFG_ACCU_OFFSET: r_cfg.accu_offset <= i_cfg_wdata[OFS_W-1:0];
                CFG_ACCU_SCALE:  r_cfg.accu_scale  <= i_cfg_wdata[SCALE_W-1:0];
                CFG_MIN_VOLT:    r_cfg.min_voltage <= i_cfg_wdata[VOLT_W-1:0];
                CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_wdata[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    pvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    pvm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_channel   (i_in.channel),
        .i_high_us   (i_in.high_us),
        .i_low_us    (i_in.low_us),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.result_channel = result.result_channel;
    assign o_out.voltage_q8     = result.voltage_q8;
    assign o_out.frequency_q8   = result.frequency_q8;
    assign o_out.in_bounds      = result.in_bounds;
    assign o_out.retries_used   = result.retries_used;

endmodule

@@ hw/rtl/pvm_ctrl.sv @@
module pvm_ctrl
    import pvm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_MUL,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_sts.ch_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.retry ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/pvm_dp.sv @@
module pvm_dp
    import pvm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts,
    input  logic [CH_W-1:0] i_channel,
    input  logic [US_W-1:0] i_high_us,
    input  logic [US_W-1:0] i_low_us,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output t_result         o_result
);

    logic [CH_W-1:0]      r_ch;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_timeout;
    logic [SUM_W-1:0]     r_rem;
    logic [DIV_BITS-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RETRY_W-1:0]   r_retry [CHANNELS];
    logic [FREQ_W-1:0]    r_freq;
    logic                 r_ok;
    logic [RETRY_W-1:0]   r_used;
    logic signed [DIFF_W-1:0] r_diff;
    logic                 r_dpos;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_out_valid;
    t_result              r_result;

    logic [SUM_W:0]       div_trial;
    logic                 div_ge;
    logic [DIV_CNT_W-1:0] num_idx;
    logic [FREQ_W-1:0]    freq_c;
    logic                 ok_c;
    logic [RETRY_W-1:0]   cnt_c;
    logic                 retry_c;
    logic [OFS_W-1:0]     ofs_c;
    logic [SCALE_W-1:0]   scale_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic [PROD_W-SCALE_W-1:0] vraw_c;
    logic [VOLT_W-1:0]    vsat_c;
    logic [VOLT_W-1:0]    volt_c;

    // Restoring divider step: bring down the next numerator bit
    assign num_idx   = DIV_CNT_W'(DIV_BITS - 1) - r_cnt;
    assign div_trial = {r_rem, FREQ_NUM[num_idx]};
    assign div_ge    = (div_trial >= {1'b0, r_sum});

    // Frequency with timeout and saturation, then window check
    always_comb begin
        if (r_timeout) begin
            freq_c = '0;
        end else if (r_sum <= SAT_SUM) begin
            freq_c = FREQ_MAX;
        end else begin
            freq_c = r_quo[FREQ_W-1:0];
        end
    end
    assign ok_c    = (freq_c >= F_LOW) && (freq_c <= F_HIGH);
    assign cnt_c   = r_retry[r_ch];
    assign retry_c = !ok_c && (cnt_c < i_cfg.retry_limit);

    // Per-channel calibration
    assign ofs_c   = (r_ch == '0) ? i_cfg.ts_offset : i_cfg.accu_offset;
    assign scale_c = (r_ch == '0) ? i_cfg.ts_scale  : i_cfg.accu_scale;
    assign diff_c  = $signed({2'b00, freq_c})
                   - $signed({{(DIFF_W-OFS_W){ofs_c[OFS_W-1]}}, ofs_c});

    // Voltage: drop fraction, saturate, apply threshold
    assign vraw_c = r_prod[PROD_W-1:SCALE_W];
    assign vsat_c = (vraw_c > (PROD_W-SCALE_W)'(VOLT_MAX)) ? VOLT_MAX
                                                           : vraw_c[VOLT_W-1:0];
    assign volt_c = (r_dpos && (vsat_c > i_cfg.min_voltage)) ? vsat_c : '0;

    // Status to the controller
    assign o_sts.ch_ok    = (32'(i_channel) < CHANNELS);
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_BITS - 1));
    assign o_sts.retry    = retry_c;
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch      <= i_channel;
            r_sum     <= {1'b0, i_high_us} + {1'b0, i_low_us};
            r_timeout <= (i_high_us == '0) || (i_low_us == '0);
            r_rem     <= '0;
            r_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? SUM_W'(div_trial - {1'b0, r_sum}) : div_trial[SUM_W-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], div_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.check) begin
            r_freq <= freq_c;
            r_ok   <= ok_c;
            r_used <= cnt_c;
            r_diff <= diff_c;
        end
        if (i_cmd.mul) begin
            r_dpos <= !r_diff[DIFF_W-1] && (r_diff != '0);
            r_prod <= {{SCALE_W{1'b0}}, r_diff[DIFF_W-2:0]}
                    * {{(DIFF_W-1){1'b0}}, scale_c};
        end
        if (i_cmd.emit) begin
            r_result.result_channel <= r_ch;
            r_result.voltage_q8     <= volt_c;
            r_result.frequency_q8   <= r_freq;
            r_result.in_bounds      <= r_ok;
            r_result.retries_used   <= r_used;
        end
    end

    // Retry counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_retry[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                r_retry[r_ch] <= retry_c ? cnt_c + 1'b1 : '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
